FILE: src/gray_code_plane_accumulator_core_assert.svh
// ----------------------------------------------------------------------------
// gray code plane accumulator assertion macros
// concurrent checks that drop out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef GRAY_CODE_PLANE_ACCUMULATOR_CORE_ASSERT_SVH
`define GRAY_CODE_PLANE_ACCUMULATOR_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define GCPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcpa assertion failed");
// next-cycle implication
`define GCPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcpa assertion failed");
`else
`define GCPA_ASSERT_NOW(label, clk, rst, ante, cons)
`define GCPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: src/gcpa_pkg.sv
// ----------------------------------------------------------------------------
// gcpa_pkg
// shared types, constants and the luma function of the plane accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcpa_pkg;

   localparam int PIX_W      = 8;
   localparam int CODE_W     = 16;
   localparam int CLASS_W    = 2;
   localparam int SUM_W      = 32;
   localparam int COUNT_W    = 24;
   localparam int PLANE_IDX_W = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   localparam int MAX_PLANES_DEF = 16;
   localparam int CODE_BITS_DEF  = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_INDEX = 4'd1;

   // pixel classes
   localparam logic [CLASS_W-1:0] CLS_SKIP    = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_ZERO    = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_ONE     = 2'd2;
   localparam logic [CLASS_W-1:0] CLS_INVALID = 2'd3;

   // q0.16 luma weights, sum is 65536
   localparam logic [23:0] W_RED   = 24'd19595;
   localparam logic [23:0] W_GREEN = 24'd38470;
   localparam logic [23:0] W_BLUE  = 24'd7471;

   typedef struct packed {
      logic [PIX_W-1:0]  pat_red;
      logic [PIX_W-1:0]  pat_green;
      logic [PIX_W-1:0]  pat_blue;
      logic [PIX_W-1:0]  inv_red;
      logic [PIX_W-1:0]  inv_green;
      logic [PIX_W-1:0]  inv_blue;
      logic [CODE_W-1:0] code_in;
   } req_data_type;

   typedef struct packed {
      logic              skip;
      logic              pat_gt;
      logic [CODE_W-1:0] code_shift;
      logic [PIX_W-1:0]  diff;
      logic [PIX_W-1:0]  bright_red;
      logic [PIX_W-1:0]  bright_green;
      logic [PIX_W-1:0]  bright_blue;
   } luma_data_type;

   typedef struct packed {
      logic             write;
      logic             add;
      logic [PIX_W-1:0] diff;
   } stats_req_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code_out;
      logic [CLASS_W-1:0] pixel_class;
      logic               color_valid;
      logic [PIX_W-1:0]   color_red;
      logic [PIX_W-1:0]   color_green;
      logic [PIX_W-1:0]   color_blue;
      logic [PIX_W-1:0]   contrast;
      logic [SUM_W-1:0]   plane_sum;
      logic [COUNT_W-1:0] plane_count;
   } rsp_data_type;

   function automatic logic [PIX_W-1:0] luma(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b);
      logic [23:0] acc;
      acc = W_RED * 24'(r) + W_GREEN * 24'(g) + W_BLUE * 24'(b);
      return acc[23:16];
   endfunction

endpackage

`default_nettype wire

FILE: src/gcpa_req_if.sv
// ----------------------------------------------------------------------------
// gcpa_req_if
// pixel transaction channel: two captures and the current code word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gcpa_req_if;
   logic                          valid;
   logic                          ready;
   logic [gcpa_pkg::PIX_W-1:0]    pat_red;
   logic [gcpa_pkg::PIX_W-1:0]    pat_green;
   logic [gcpa_pkg::PIX_W-1:0]    pat_blue;
   logic [gcpa_pkg::PIX_W-1:0]    inv_red;
   logic [gcpa_pkg::PIX_W-1:0]    inv_green;
   logic [gcpa_pkg::PIX_W-1:0]    inv_blue;
   logic [gcpa_pkg::CODE_W-1:0]   code_in;

   modport source (output valid, pat_red, pat_green, pat_blue, inv_red, inv_green,
                   inv_blue, code_in, input ready);
   modport sink (input valid, pat_red, pat_green, pat_blue, inv_red, inv_green,
                 inv_blue, code_in, output ready);
endinterface

`default_nettype wire

FILE: src/gcpa_rsp_if.sv
// ----------------------------------------------------------------------------
// gcpa_rsp_if
// result transaction channel: updated code word and plane statistics
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gcpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gcpa_pkg::CODE_W-1:0]   code_out;
   logic [gcpa_pkg::CLASS_W-1:0]  pixel_class;
   logic                          color_valid;
   logic [gcpa_pkg::PIX_W-1:0]    color_red;
   logic [gcpa_pkg::PIX_W-1:0]    color_green;
   logic [gcpa_pkg::PIX_W-1:0]    color_blue;
   logic [gcpa_pkg::PIX_W-1:0]    contrast;
   logic [gcpa_pkg::SUM_W-1:0]    plane_sum;
   logic [gcpa_pkg::COUNT_W-1:0]  plane_count;

   modport source (output valid, code_out, pixel_class, color_valid, color_red,
                   color_green, color_blue, contrast, plane_sum, plane_count,
                   input ready);
   modport sink (input valid, code_out, pixel_class, color_valid, color_red,
                 color_green, color_blue, contrast, plane_sum, plane_count,
                 output ready);
endinterface

`default_nettype wire

FILE: src/gcpa_csr_if.sv
// ----------------------------------------------------------------------------
// gcpa_csr_if
// register write channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gcpa_csr_if;
   logic                              valid;
   logic                              ready;
   logic [gcpa_pkg::CSR_IDX_W-1:0]    index;
   logic [gcpa_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/gcpa_plane_stats.sv
// ----------------------------------------------------------------------------
// gcpa_plane_stats
// per-plane saturating contrast sum and valid count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcpa_plane_stats #(
   parameter int MAX_PLANES = gcpa_pkg::MAX_PLANES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire gcpa_pkg::stats_req_type             stats_req,
   input  wire logic [gcpa_pkg::PLANE_IDX_W-1:0]    plane_index,
   output logic      [gcpa_pkg::SUM_W-1:0]          sum_next,
   output logic      [gcpa_pkg::COUNT_W-1:0]        count_next
);

   localparam int PLANE_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

   logic [gcpa_pkg::SUM_W-1:0]   sum_ff   [MAX_PLANES];
   logic [gcpa_pkg::COUNT_W-1:0] count_ff [MAX_PLANES];

   logic                          plane_ok;
   logic [PLANE_W-1:0]            idx;
   logic [gcpa_pkg::SUM_W-1:0]    cur_sum;
   logic [gcpa_pkg::COUNT_W-1:0]  cur_count;
   logic [gcpa_pkg::SUM_W:0]      sum_wide;
   logic [gcpa_pkg::SUM_W-1:0]    sat_sum;
   logic [gcpa_pkg::COUNT_W-1:0]  sat_count;
   logic                          do_add;

   assign plane_ok = {1'b0, plane_index} < (gcpa_pkg::PLANE_IDX_W + 1)'(MAX_PLANES);
   assign idx      = plane_index[PLANE_W-1:0];
   assign do_add   = stats_req.add && plane_ok;

   always_comb begin
      cur_sum   = plane_ok ? sum_ff[idx] : '0;
      cur_count = plane_ok ? count_ff[idx] : '0;
      sum_wide  = {1'b0, cur_sum} + (gcpa_pkg::SUM_W + 1)'(stats_req.diff);
      sat_sum   = sum_wide[gcpa_pkg::SUM_W] ? '1 : sum_wide[gcpa_pkg::SUM_W-1:0];
      sat_count = (&cur_count) ? cur_count : cur_count + 1'b1;
      sum_next   = do_add ? sat_sum : cur_sum;
      count_next = do_add ? sat_count : cur_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PLANES; i++) begin
            sum_ff[i]   <= '0;
            count_ff[i] <= '0;
         end
      end else if (stats_req.write && do_add) begin
         sum_ff[idx]   <= sat_sum;
         count_ff[idx] <= sat_count;
      end
   end

endmodule

`default_nettype wire

FILE: src/gcpa_luma_stage.sv
// ----------------------------------------------------------------------------
// gcpa_luma_stage
// luma of both captures, contrast, brighter colour and shifted code
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcpa_luma_stage #(
   parameter int CODE_BITS = gcpa_pkg::CODE_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     load,
   input  wire gcpa_pkg::req_data_type   req_data,
   output gcpa_pkg::luma_data_type       luma_data
);

   localparam logic [gcpa_pkg::CODE_W-1:0] CODE_MASK =
      gcpa_pkg::CODE_W'((32'd1 << CODE_BITS) - 32'd1);

   gcpa_pkg::luma_data_type    luma_ff;
   gcpa_pkg::luma_data_type    luma_in;
   logic [gcpa_pkg::PIX_W-1:0] y_pat;
   logic [gcpa_pkg::PIX_W-1:0] y_inv;
   logic [gcpa_pkg::CODE_W-1:0] code;

   always_comb begin
      y_pat = gcpa_pkg::luma(req_data.pat_red, req_data.pat_green, req_data.pat_blue);
      y_inv = gcpa_pkg::luma(req_data.inv_red, req_data.inv_green, req_data.inv_blue);
      code  = req_data.code_in & CODE_MASK;

      luma_in.skip       = (code == CODE_MASK);
      luma_in.pat_gt     = (y_pat > y_inv);
      luma_in.code_shift = {code[gcpa_pkg::CODE_W-2:0], 1'b0} & CODE_MASK;
      luma_in.diff       = luma_in.pat_gt ? (y_pat - y_inv) : (y_inv - y_pat);
      // brighter capture, the inverse wins ties
      luma_in.bright_red   = luma_in.pat_gt ? req_data.pat_red   : req_data.inv_red;
      luma_in.bright_green = luma_in.pat_gt ? req_data.pat_green : req_data.inv_green;
      luma_in.bright_blue  = luma_in.pat_gt ? req_data.pat_blue  : req_data.inv_blue;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         luma_ff <= luma_in;
      end
   end

   assign luma_data = luma_ff;

endmodule

`default_nettype wire

FILE: src/gcpa_decide_stage.sv
// ----------------------------------------------------------------------------
// gcpa_decide_stage
// threshold decision, code update, statistics and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcpa_decide_stage #(
   parameter int MAX_PLANES = gcpa_pkg::MAX_PLANES_DEF,
   parameter int CODE_BITS  = gcpa_pkg::CODE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                load,
   input  wire gcpa_pkg::luma_data_type             luma_data,
   input  wire logic [gcpa_pkg::PIX_W-1:0]          threshold,
   input  wire logic [gcpa_pkg::PLANE_IDX_W-1:0]    plane_index,
   output gcpa_pkg::rsp_data_type                   rsp_data
);

   localparam logic [gcpa_pkg::CODE_W-1:0] CODE_MASK =
      gcpa_pkg::CODE_W'((32'd1 << CODE_BITS) - 32'd1);

   gcpa_pkg::rsp_data_type        rsp_ff;
   gcpa_pkg::rsp_data_type        rsp_in;
   gcpa_pkg::stats_req_type       stats_req;
   logic                          hit;
   logic [gcpa_pkg::SUM_W-1:0]    sum_next;
   logic [gcpa_pkg::COUNT_W-1:0]  count_next;

   assign hit = !luma_data.skip && (luma_data.diff > threshold);

   always_comb begin
      stats_req.write = load;
      stats_req.add   = hit;
      stats_req.diff  = luma_data.diff;
   end

   gcpa_plane_stats #(
      .MAX_PLANES (MAX_PLANES)
   ) u_stats (
      .clock       (clock),
      .reset       (reset),
      .stats_req   (stats_req),
      .plane_index (plane_index),
      .sum_next    (sum_next),
      .count_next  (count_next)
   );

   always_comb begin
      rsp_in.color_valid = hit;
      rsp_in.color_red   = hit ? luma_data.bright_red   : '0;
      rsp_in.color_green = hit ? luma_data.bright_green : '0;
      rsp_in.color_blue  = hit ? luma_data.bright_blue  : '0;
      rsp_in.contrast    = luma_data.skip ? '0 : luma_data.diff;
      rsp_in.plane_sum   = sum_next;
      rsp_in.plane_count = count_next;
      if (luma_data.skip) begin
         rsp_in.code_out    = CODE_MASK;
         rsp_in.pixel_class = gcpa_pkg::CLS_SKIP;
      end else if (hit && luma_data.pat_gt) begin
         rsp_in.code_out    = luma_data.code_shift | gcpa_pkg::CODE_W'(1);
         rsp_in.pixel_class = gcpa_pkg::CLS_ONE;
      end else if (hit) begin
         rsp_in.code_out    = luma_data.code_shift;
         rsp_in.pixel_class = gcpa_pkg::CLS_ZERO;
      end else begin
         rsp_in.code_out    = CODE_MASK;
         rsp_in.pixel_class = gcpa_pkg::CLS_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: src/gray_code_plane_accumulator_core.sv
// path: an accepted req passes the input, luma and result registers in turn before rsp valid is seen
// throughput: one transaction per cycle while rsp is ready, set by the single stats update per pixel
// rsp backpressure stalls the three stages; req stays ready while a stage is free
// reset: synchronous, clears valid bits, threshold, plane index and all plane stats
// plane stats are flip-flops cleared in the reset cycle, no clearing pass
// ----------------------------------------------------------------------------
// gray_code_plane_accumulator_core
// structured-light gray code bit-plane decoder with per-plane contrast stats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gray_code_plane_accumulator_core_assert.svh"

module gray_code_plane_accumulator_core #(
   parameter int MAX_PLANES = gcpa_pkg::MAX_PLANES_DEF,
   parameter int CODE_BITS  = gcpa_pkg::CODE_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   gcpa_req_if.sink     req_bus,
   gcpa_rsp_if.source   rsp_bus,
   gcpa_csr_if.sink     csr_bus
);

   // ------------------------------------------------------------------
   // configuration registers, writes are always taken
   // ------------------------------------------------------------------
   logic [gcpa_pkg::PIX_W-1:0]       threshold_ff;
   logic [gcpa_pkg::PIX_W-1:0]       threshold_in;
   logic [gcpa_pkg::PLANE_IDX_W-1:0] plane_index_ff;
   logic [gcpa_pkg::PLANE_IDX_W-1:0] plane_index_in;
   logic                             csr_write;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      threshold_in   = threshold_ff;
      plane_index_in = plane_index_ff;
      if (csr_write) begin
         unique case (csr_bus.index)
            gcpa_pkg::REG_THRESHOLD:   threshold_in = csr_bus.data;
            gcpa_pkg::REG_PLANE_INDEX: plane_index_in =
               csr_bus.data[gcpa_pkg::PLANE_IDX_W-1:0];
            default: ;  // unmapped index, write is dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= '0;
         plane_index_ff <= '0;
      end else begin
         threshold_ff   <= threshold_in;
         plane_index_ff <= plane_index_in;
      end
   end

   // ------------------------------------------------------------------
   // pipeline flow control: each stage loads when empty or draining
   // ------------------------------------------------------------------
   logic in_valid_ff,   in_valid_in;
   logic luma_valid_ff, luma_valid_in;
   logic rsp_valid_ff,  rsp_valid_in;
   logic in_ready, luma_ready, rsp_stage_ready;
   logic load_in, load_luma, load_rsp;

   assign rsp_stage_ready = !rsp_valid_ff || rsp_bus.ready;
   assign luma_ready      = !luma_valid_ff || rsp_stage_ready;
   assign in_ready        = !in_valid_ff || luma_ready;

   assign load_in   = req_bus.valid && in_ready;
   assign load_luma = in_valid_ff && luma_ready;
   assign load_rsp  = luma_valid_ff && rsp_stage_ready;

   assign in_valid_in   = load_in || (in_valid_ff && !luma_ready);
   assign luma_valid_in = load_luma || (luma_valid_ff && !rsp_stage_ready);
   assign rsp_valid_in  = load_rsp || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         luma_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         luma_valid_ff <= luma_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_bus.ready = in_ready;

   // ------------------------------------------------------------------
   // input register
   // ------------------------------------------------------------------
   gcpa_pkg::req_data_type req_data_ff;
   gcpa_pkg::req_data_type req_data_in;

   always_comb begin
      req_data_in.pat_red   = req_bus.pat_red;
      req_data_in.pat_green = req_bus.pat_green;
      req_data_in.pat_blue  = req_bus.pat_blue;
      req_data_in.inv_red   = req_bus.inv_red;
      req_data_in.inv_green = req_bus.inv_green;
      req_data_in.inv_blue  = req_bus.inv_blue;
      req_data_in.code_in   = req_bus.code_in;
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         req_data_ff <= req_data_in;
      end
   end

   // ------------------------------------------------------------------
   // luma stage and decision stage
   // ------------------------------------------------------------------
   gcpa_pkg::luma_data_type luma_data;
   gcpa_pkg::rsp_data_type  rsp_data;

   gcpa_luma_stage #(
      .CODE_BITS (CODE_BITS)
   ) u_luma (
      .clock     (clock),
      .load      (load_luma),
      .req_data  (req_data_ff),
      .luma_data (luma_data)
   );

   // stats are read and written here, so back-to-back pixels on one plane
   // always see the previous update
   gcpa_decide_stage #(
      .MAX_PLANES (MAX_PLANES),
      .CODE_BITS  (CODE_BITS)
   ) u_decide (
      .clock       (clock),
      .reset       (reset),
      .load        (load_rsp),
      .luma_data   (luma_data),
      .threshold   (threshold_ff),
      .plane_index (plane_index_ff),
      .rsp_data    (rsp_data)
   );

   // ------------------------------------------------------------------
   // result channel
   // ------------------------------------------------------------------
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.code_out    = rsp_data.code_out;
   assign rsp_bus.pixel_class = rsp_data.pixel_class;
   assign rsp_bus.color_valid = rsp_data.color_valid;
   assign rsp_bus.color_red   = rsp_data.color_red;
   assign rsp_bus.color_green = rsp_data.color_green;
   assign rsp_bus.color_blue  = rsp_data.color_blue;
   assign rsp_bus.contrast    = rsp_data.contrast;
   assign rsp_bus.plane_sum   = rsp_data.plane_sum;
   assign rsp_bus.plane_count = rsp_data.plane_count;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // a skipped pixel carries no colour and no contrast
   `GCPA_ASSERT_NOW(a_skip_quiet, clock, reset, rsp_valid_ff && rsp_data.pixel_class == gcpa_pkg::CLS_SKIP, !rsp_data.color_valid && rsp_data.contrast == '0)
   // colour is emitted exactly for a decoded bit
   `GCPA_ASSERT_NOW(a_color_class, clock, reset, rsp_valid_ff, rsp_data.color_valid == (rsp_data.pixel_class == gcpa_pkg::CLS_ONE || rsp_data.pixel_class == gcpa_pkg::CLS_ZERO))
   // a pixel that failed the threshold had low contrast
   `GCPA_ASSERT_NOW(a_invalid_low, clock, reset, rsp_valid_ff && rsp_data.pixel_class == gcpa_pkg::CLS_INVALID, rsp_data.contrast <= threshold_ff)
   // the appended bit matches the class
   `GCPA_ASSERT_NOW(a_bit_class, clock, reset, rsp_valid_ff && rsp_data.color_valid, rsp_data.code_out[0] == (rsp_data.pixel_class == gcpa_pkg::CLS_ONE))
   // a luma entry moved into the result register shows rsp valid next cycle
   `GCPA_ASSERT_NEXT(a_luma_to_rsp, clock, reset, load_rsp, rsp_valid_ff)

endmodule

`default_nettype wire

FILE: test/gray_code_plane_accumulator_core_tb.sv
// ----------------------------------------------------------------------------
// gray_code_plane_accumulator_core_tb
// self-checking bench: pixel transactions go in under random idling and
// backpressure, and every result is compared against a bit-exact decode of
// the luma contrast, code word update and per-plane statistics
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gray_code_plane_accumulator_core_tb;

   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          PHASE_ITEMS  = 135;
   localparam int          PRESSURE_LEN = 300;
   localparam int          SLOT_COUNT   = 8;
   localparam logic [15:0] CODE_MARK    = 16'hFFFF;

   // ------------------------------------------------------------------------
   // decoder state mirror plus the list of decoded pixels still owed
   // ------------------------------------------------------------------------
   class gray_decode_tracker;
      logic [7:0]   threshold;
      logic [3:0]   plane_sel;
      logic [31:0]  contrast_sum [gcpa_pkg::MAX_PLANES_DEF];
      logic [23:0]  valid_count [gcpa_pkg::MAX_PLANES_DEF];
      gcpa_pkg::rsp_data_type decoded_q [$];
      int           errors;

      function new();
         threshold = '0;
         plane_sel = '0;
         errors    = 0;
         foreach (contrast_sum[i]) begin
            contrast_sum[i] = '0;
            valid_count[i]  = '0;
         end
      endfunction

      function void set_reg(input logic [gcpa_pkg::CSR_IDX_W-1:0] idx,
                            input logic [gcpa_pkg::CSR_DATA_W-1:0] value);
         if (idx == gcpa_pkg::REG_THRESHOLD) threshold = value;
         else if (idx == gcpa_pkg::REG_PLANE_INDEX) plane_sel = value[3:0];
      endfunction

      function logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b);
         logic [31:0] weighted;
         weighted = 32'd19595 * r + 32'd38470 * g + 32'd7471 * b;
         return weighted[23:16];
      endfunction

      // decode one accepted pixel, update the stats, return the new code word
      function logic [15:0] accept_pixel(input gcpa_pkg::req_data_type px);
         gcpa_pkg::rsp_data_type want;
         logic [7:0]   y_pat, y_inv, diff;
         logic [15:0]  code;
         bit           plane_ok;
         want     = '0;
         code     = px.code_in;
         plane_ok = int'(plane_sel) < gcpa_pkg::MAX_PLANES_DEF;
         want.pixel_class = gcpa_pkg::CLS_SKIP;
         if (code != CODE_MARK) begin
            y_pat = luma_of(px.pat_red, px.pat_green, px.pat_blue);
            y_inv = luma_of(px.inv_red, px.inv_green, px.inv_blue);
            diff  = (y_pat >= y_inv) ? y_pat - y_inv : y_inv - y_pat;
            want.contrast = diff;
            code = code << 1;
            if (diff > threshold) begin
               if (plane_ok) begin
                  if (contrast_sum[plane_sel] > 32'hFFFF_FFFF - 32'(diff))
                     contrast_sum[plane_sel] = 32'hFFFF_FFFF;
                  else
                     contrast_sum[plane_sel] = contrast_sum[plane_sel] + 32'(diff);
                  if (valid_count[plane_sel] != 24'hFF_FFFF)
                     valid_count[plane_sel] = valid_count[plane_sel] + 24'd1;
               end
               want.color_valid = 1'b1;
               if (y_pat > y_inv) begin
                  code[0]          = 1'b1;
                  want.pixel_class = gcpa_pkg::CLS_ONE;
                  want.color_red   = px.pat_red;
                  want.color_green = px.pat_green;
                  want.color_blue  = px.pat_blue;
               end else begin
                  want.pixel_class = gcpa_pkg::CLS_ZERO;
                  want.color_red   = px.inv_red;
                  want.color_green = px.inv_green;
                  want.color_blue  = px.inv_blue;
               end
            end else begin
               code             = CODE_MARK;
               want.pixel_class = gcpa_pkg::CLS_INVALID;
            end
         end
         want.code_out    = code;
         want.plane_sum   = plane_ok ? contrast_sum[plane_sel] : '0;
         want.plane_count = plane_ok ? valid_count[plane_sel] : '0;
         decoded_q.push_back(want);
         return code;
      endfunction

      function int pending();
         return decoded_q.size();
      endfunction

      task report_mismatch(input string what, input logic [31:0] got,
                           input logic [31:0] want);
         errors++;
         if (errors <= 40)
            $display("[%0t] mismatch %s: got 'h%0h, want 'h%0h", $time, what, got, want);
      endtask

      task check_decoded(input gcpa_pkg::rsp_data_type got);
         gcpa_pkg::rsp_data_type want;
         if (decoded_q.size() == 0) begin
            report_mismatch("unexpected result", 32'(got.code_out), '0);
            return;
         end
         want = decoded_q.pop_front();
         if (got.code_out !== want.code_out)
            report_mismatch("code_out", 32'(got.code_out), 32'(want.code_out));
         if (got.pixel_class !== want.pixel_class)
            report_mismatch("pixel_class", 32'(got.pixel_class), 32'(want.pixel_class));
         if (got.color_valid !== want.color_valid)
            report_mismatch("color_valid", 32'(got.color_valid), 32'(want.color_valid));
         if (got.color_red !== want.color_red)
            report_mismatch("color_red", 32'(got.color_red), 32'(want.color_red));
         if (got.color_green !== want.color_green)
            report_mismatch("color_green", 32'(got.color_green), 32'(want.color_green));
         if (got.color_blue !== want.color_blue)
            report_mismatch("color_blue", 32'(got.color_blue), 32'(want.color_blue));
         if (got.contrast !== want.contrast)
            report_mismatch("contrast", 32'(got.contrast), 32'(want.contrast));
         if (got.plane_sum !== want.plane_sum)
            report_mismatch("plane_sum", got.plane_sum, want.plane_sum);
         if (got.plane_count !== want.plane_count)
            report_mismatch("plane_count", 32'(got.plane_count), 32'(want.plane_count));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // clock, reset, channels and the block itself
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   gcpa_req_if req_bus ();
   gcpa_rsp_if rsp_bus ();
   gcpa_csr_if csr_bus ();

   gray_code_plane_accumulator_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   gray_decode_tracker tracker = new();

   // idling knobs, set per phase by the stimulus process
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   // long receiver hold-off, counted down by the ready driver
   int          hold_cycles   = 0;
   int          cycle_count   = 0;

   // ------------------------------------------------------------------------
   // driver tasks, all inputs change on the falling edge
   // ------------------------------------------------------------------------
   function automatic gcpa_pkg::req_data_type make_pixel(
      input logic [7:0] pr, input logic [7:0] pg, input logic [7:0] pb,
      input logic [7:0] ir, input logic [7:0] ig, input logic [7:0] ib,
      input logic [15:0] code);
      gcpa_pkg::req_data_type px;
      px.pat_red   = pr;
      px.pat_green = pg;
      px.pat_blue  = pb;
      px.inv_red   = ir;
      px.inv_green = ig;
      px.inv_blue  = ib;
      px.code_in   = code;
      return px;
   endfunction

   // random capture pair; some pairs land near each other to hit the threshold
   function automatic gcpa_pkg::req_data_type random_pixel(input logic [15:0] code);
      gcpa_pkg::req_data_type px;
      int unsigned  kind;
      logic [7:0]   level;
      kind = $urandom_range(0, 9);
      px   = make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom), code);
      if (kind >= 6 && kind < 8) begin
         // near-equal captures
         px.inv_red   = px.pat_red + 8'($urandom_range(0, 40)) - 8'd20;
         px.inv_green = px.pat_green + 8'($urandom_range(0, 40)) - 8'd20;
         px.inv_blue  = px.pat_blue + 8'($urandom_range(0, 40)) - 8'd20;
      end else if (kind >= 8) begin
         // gray captures, luma equals the level exactly
         level        = 8'($urandom);
         px.pat_red   = level;
         px.pat_green = level;
         px.pat_blue  = level;
         level        = 8'($urandom);
         px.inv_red   = level;
         px.inv_green = level;
         px.inv_blue  = level;
      end
      return px;
   endfunction

   // offer one pixel transaction and hold it until accepted
   task automatic send_pixel(input gcpa_pkg::req_data_type px,
                             output logic [15:0] next_code);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.pat_red   <= px.pat_red;
      req_bus.pat_green <= px.pat_green;
      req_bus.pat_blue  <= px.pat_blue;
      req_bus.inv_red   <= px.inv_red;
      req_bus.inv_green <= px.inv_green;
      req_bus.inv_blue  <= px.inv_blue;
      req_bus.code_in   <= px.code_in;
      do @(posedge clock); while (!req_bus.ready);
      next_code = tracker.accept_pixel(px);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic write_reg(input logic [gcpa_pkg::CSR_IDX_W-1:0] idx,
                            input logic [gcpa_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.set_reg(idx, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // every item gives one result, so an empty list means the pipe is idle
   task automatic wait_drained();
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result side: ready driver and monitor
   // ------------------------------------------------------------------------
   initial begin : rsp_ready_driver
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            // long hold-off so the pipe backs up into the request side
            rsp_bus.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin : rsp_monitor
      gcpa_pkg::rsp_data_type seen;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            seen.code_out    = rsp_bus.code_out;
            seen.pixel_class = rsp_bus.pixel_class;
            seen.color_valid = rsp_bus.color_valid;
            seen.color_red   = rsp_bus.color_red;
            seen.color_green = rsp_bus.color_green;
            seen.color_blue  = rsp_bus.color_blue;
            seen.contrast    = rsp_bus.contrast;
            seen.plane_sum   = rsp_bus.plane_sum;
            seen.plane_count = rsp_bus.plane_count;
            tracker.check_decoded(seen);
         end
      end
   end

   // hard stop if the run hangs
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("gray_code_plane_accumulator_core verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned phase_send [4];
      int unsigned phase_stall [4];
      logic [15:0] slot_code [SLOT_COUNT];
      logic [15:0] next_code;
      int unsigned slot;
      gcpa_pkg::req_data_type px;

      phase_send  = '{0, 52, 0, 10};
      phase_stall = '{0, 0, 52, 10};
      foreach (slot_code[i]) slot_code[i] = 16'($urandom);

      req_bus.valid     = 1'b0;
      req_bus.pat_red   = '0;
      req_bus.pat_green = '0;
      req_bus.pat_blue  = '0;
      req_bus.inv_red   = '0;
      req_bus.inv_green = '0;
      req_bus.inv_blue  = '0;
      req_bus.code_in   = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // reset defaults: threshold 0, plane 0
      // equal captures never beat a zero threshold
      send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 16'h0000), next_code);
      // full white against black, one bit
      send_pixel(make_pixel(255, 255, 255, 0, 0, 0, 16'h0000), next_code);
      // inverse brighter, zero bit
      send_pixel(make_pixel(0, 0, 0, 255, 255, 255, 16'h5555), next_code);
      // already invalid code passes through
      send_pixel(make_pixel(255, 255, 255, 0, 0, 0, CODE_MARK), next_code);
      // valid code shifted straight into the invalid mark
      send_pixel(make_pixel(200, 200, 200, 10, 10, 10, 16'h7FFF), next_code);
      // top bit shifted out
      send_pixel(make_pixel(0, 0, 0, 90, 90, 90, 16'h8000), next_code);
      send_pixel(make_pixel(128, 64, 32, 0, 0, 0, 16'hFFFE), next_code);
      // single channel extremes exercise each weight
      send_pixel(make_pixel(255, 0, 0, 0, 255, 0, 16'h00FF), next_code);
      send_pixel(make_pixel(0, 0, 255, 0, 0, 0, 16'hFF00), next_code);
      send_pixel(make_pixel(255, 0, 255, 0, 255, 0, 16'h0F0F), next_code);
      // smallest contrast that counts
      send_pixel(make_pixel(1, 1, 1, 0, 0, 0, 16'hF0F0), next_code);

      // highest threshold, last plane: nothing can count
      stop_sending();
      wait_drained();
      write_reg(gcpa_pkg::REG_THRESHOLD, 8'd255);
      write_reg(gcpa_pkg::REG_PLANE_INDEX, 8'd15);
      send_pixel(make_pixel(255, 255, 255, 0, 0, 0, 16'h1234), next_code);
      send_pixel(make_pixel(0, 0, 0, 255, 255, 255, CODE_MARK), next_code);

      // threshold boundary on gray captures, plane 7
      stop_sending();
      wait_drained();
      write_reg(gcpa_pkg::REG_THRESHOLD, 8'd100);
      write_reg(gcpa_pkg::REG_PLANE_INDEX, 8'd7);
      send_pixel(make_pixel(150, 150, 150, 50, 50, 50, 16'h0001), next_code);
      send_pixel(make_pixel(151, 151, 151, 50, 50, 50, 16'h0002), next_code);
      send_pixel(make_pixel(50, 50, 50, 151, 151, 151, 16'h4000), next_code);
      send_pixel(make_pixel(50, 50, 50, 150, 150, 150, 16'hAAAA), next_code);
      // skipped pixel still reports the plane stats
      send_pixel(make_pixel(255, 255, 255, 0, 0, 0, CODE_MARK), next_code);

      // back to plane 0, its stats must have been kept
      stop_sending();
      wait_drained();
      write_reg(gcpa_pkg::REG_PLANE_INDEX, 8'd0);
      send_pixel(make_pixel(200, 200, 200, 0, 0, 0, 16'h1234), next_code);

      // random phases: each pixel slot carries its code word from plane to plane
      for (int ph = 0; ph < 4; ph++) begin
         stop_sending();
         wait_drained();
         write_reg(gcpa_pkg::REG_THRESHOLD, 8'($urandom_range(0, (ph == 0) ? 30 : 90)));
         write_reg(gcpa_pkg::REG_PLANE_INDEX,
                   8'($urandom_range(0, gcpa_pkg::MAX_PLANES_DEF - 1)));
         send_idle_pct = phase_send[ph];
         stall_pct     = phase_stall[ph];
         if (ph == 0) hold_cycles = PRESSURE_LEN;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            slot = $urandom_range(0, SLOT_COUNT - 1);
            // occasionally start a fresh pixel, sometimes from all zeros
            if ($urandom_range(0, 7) == 0)
               slot_code[slot] = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom);
            px = random_pixel(slot_code[slot]);
            send_pixel(px, next_code);
            slot_code[slot] = next_code;
         end
      end

      stop_sending();
      wait_drained();
      // a few more cycles to catch stray results
      repeat (10) @(posedge clock);

      if (tracker.errors == 0)
         $display("gray_code_plane_accumulator_core verification clean");
      else
         $display("gray_code_plane_accumulator_core verification failed");
      $finish;
   end

endmodule
